/* sv/wfpn_pkg.sv */
// Package: payload types, codes, constants and reset values of the wall follower.
`default_nettype none

package wfpn_pkg;

  localparam int DEF_DIST_BITS  = 16;
  localparam int DEF_INTEG_BITS = 40;

  // Shift-add unit steps over multiplier bits, one bit per cycle while step is set.
  localparam int GAIN_BITS = 16;
  localparam int TICK_BITS = 8;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_TICK   = 1'b1;

  localparam logic [9:0] BEAM_RIGHT_LAST  = 10'd49;
  localparam logic [9:0] BEAM_FRONT_FIRST = 10'd51;
  localparam logic [9:0] BEAM_FRONT_LAST  = 10'd69;
  localparam logic [9:0] BEAM_COMMIT      = 10'd119;

  localparam logic [9:0] SPD_INIT = 10'd800;
  localparam logic [9:0] SPD_SLOW = 10'd400;
  localparam logic [9:0] SPD_FAST = 10'd600;

  localparam logic [15:0] RST_DESIRED = 16'd700;
  localparam logic [15:0] RST_CLEAR   = 16'd800;
  localparam logic [15:0] RST_SLOW    = 16'd1000;
  localparam logic [15:0] RST_PGAIN   = 16'd256;
  localparam logic [15:0] RST_IGAIN   = 16'd26;
  localparam logic [7:0]  RST_PERIOD  = 8'd26;
  localparam logic [7:0]  RST_INITT   = 8'd30;
  localparam logic [14:0] RST_TURN    = 15'd15708;

  typedef enum logic [2:0] {
    REG_DESIRED,
    REG_CLEAR,
    REG_SLOW,
    REG_PGAIN,
    REG_IGAIN,
    REG_PERIOD,
    REG_INITT,
    REG_TURN
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_INIT   = 2'd0,
    MODE_FOLLOW = 2'd1,
    MODE_AVOID  = 2'd2
  } nav_mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INC,
    ST_SAT,
    ST_MUL_I,
    ST_LDP,
    ST_MUL_P,
    ST_OUT
  } nav_state_e;

  typedef struct packed {
    logic        action;
    logic [9:0]  beam_index;
    logic [15:0] range_mm;
  } nav_in_t;

  typedef struct packed {
    logic [9:0]         linear_speed;
    logic signed [15:0] angular_rate;
    logic [1:0]         mode;
  } nav_out_t;

  typedef struct packed {
    logic load;
    logic clr;
    logic step;
  } mac_ctrl_t;

endpackage

`default_nettype wire

/* sv/wfpn_mac.sv */
// Bit-serial shift-add multiply-accumulate unit, one multiplier bit per cycle while step is set.
`default_nettype none

module wfpn_mac
  import wfpn_pkg::*;
#(
  parameter int AW = 57,
  parameter int MW = GAIN_BITS
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire mac_ctrl_t     ctrl_i,
  input  wire logic [AW-1:0] mcand_i,
  input  wire logic [MW-1:0] mplier_i,
  output logic      [AW-1:0] acc_o
);

  logic [AW-1:0] mcand_q, mcand_d;
  logic [MW-1:0] mplier_q, mplier_d;
  logic [AW-1:0] acc_q, acc_d;

  always_comb begin
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    acc_d    = acc_q;
    if (ctrl_i.load) begin
      mcand_d  = mcand_i;
      mplier_d = mplier_i;
      if (ctrl_i.clr) begin
        acc_d = '0;
      end
    end else if (ctrl_i.step) begin
      if (mplier_q[0]) begin
        acc_d = acc_q + mcand_q;
      end
      mcand_d  = {mcand_q[AW-2:0], 1'b0};
      mplier_d = {1'b0, mplier_q[MW-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

/* sv/wall_follow_pi_navigator.sv */
// Top level: wall-following PI navigator, scan reduction and control modes.
//
// Input channel (in_valid_i / in_stall_o / in_data_i) carries range samples
// (action 0) and control ticks (action 1). A sample gives no result;
// beams 0..49 feed the right minimum, 51..69 the front minimum, beam 119
// commits both and restarts the scan.
// Output channel (out_valid_o / out_stall_i / out_data_o) carries one command
// per tick from an output register.
// Init and avoid ticks: result is valid the cycle after the transfer.
// Follow ticks: the result is set by the bit-serial shift-add unit: 8 steps
// for the integrator increment, a saturation state, 16 steps for the integral
// term, a reload, 16 steps for the proportional term, then an output state
// that waits for a free output register. Input is held off during that work.
// Samples keep transferring one per cycle while a result waits; a tick is
// also held off while the output register holds an untaken result.
// Reset loads the register defaults, sets all distances to the maximum, clears
// the integrator and init progress. No clearing pass. Configuration writes
// (cfg_we_i) take effect at the next edge and are meant for idle periods.
`default_nettype none

module wall_follow_pi_navigator
  import wfpn_pkg::*;
#(
  parameter int DIST_BITS       = DEF_DIST_BITS,
  parameter int INTEGRATOR_BITS = DEF_INTEG_BITS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire nav_in_t     in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output nav_out_t         out_data_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int DB   = DIST_BITS;
  localparam int IB   = INTEGRATOR_BITS;
  localparam int CMPW = (DB > 16) ? DB : 16;          // compare width vs 16-bit regs
  localparam int EW   = CMPW + 1;                      // signed distance error
  localparam int IW   = EW + TICK_BITS;                // integrator increment
  localparam int SW   = ((IB > IW) ? IB : IW) + 1;     // saturating sum
  localparam int PA   = IB + GAIN_BITS;                // integral product
  localparam int PB   = EW + 8 + GAIN_BITS;            // proportional product
  localparam int AW   = ((PA > PB) ? PA : PB) + 1;     // accumulator
  localparam int TW   = AW - 16;                       // after the /65536
  localparam int CNTW = $clog2(GAIN_BITS);

  localparam logic [DB-1:0] DIST_MAX = '1;
  localparam logic signed [SW-1:0] INTEG_MAX_S = {{(SW-IB+1){1'b0}}, {(IB-1){1'b1}}};
  localparam logic signed [SW-1:0] INTEG_MIN_S = {{(SW-IB+1){1'b1}}, {(IB-1){1'b0}}};
  localparam logic signed [TW-1:0] ANG_MAX = {{(TW-16){1'b0}}, 16'h7fff};
  localparam logic signed [TW-1:0] ANG_MIN = {{(TW-16){1'b1}}, 16'h8000};

  // configuration
  logic [15:0] desired_q, clear_q, slow_q, pgain_q, igain_q;
  logic [7:0]  period_q, initt_q;
  logic [14:0] turn_q;

  // scan and control state
  nav_state_e          state_q, state_d;
  logic [CNTW-1:0]     cnt_q, cnt_d;
  logic [DB-1:0]       rmin_q, rmin_d, fmin_q, fmin_d;
  logic [DB-1:0]       rdist_q, rdist_d, fdist_q, fdist_d;
  logic                init_done_q, init_done_d;
  logic [7:0]          wait_q, wait_d;
  logic signed [IB-1:0] integ_q, integ_d;
  logic signed [EW-1:0] err_q, err_d;

  // output register
  logic     out_valid_q;
  nav_out_t out_q, out_d;
  logic     out_load;

  // shift-add unit
  mac_ctrl_t            mac_ctrl;
  logic [AW-1:0]        mac_mcand;
  logic [GAIN_BITS-1:0] mac_mplier;
  logic [AW-1:0]        mac_acc;

  // datapath helpers
  logic                 in_take;
  logic                 slot_free;
  logic [CMPW-1:0]      rng_w;
  logic [DB-1:0]        rng_sat;
  logic                 front_gt_clear;
  logic                 front_lt_slow;
  logic signed [EW-1:0] err_now;
  logic signed [EW+7:0] err_sh;
  logic signed [IW-1:0] inc;
  logic signed [SW-1:0] sum;
  logic signed [TW-1:0] tot;

  wfpn_mac #(
    .AW(AW),
    .MW(GAIN_BITS)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mac_ctrl),
    .mcand_i (mac_mcand),
    .mplier_i(mac_mplier),
    .acc_o   (mac_acc)
  );

  // A slot opens when the register is empty or its result transfers now.
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || ((in_data_i.action == ACT_TICK) && !slot_free);
  assign in_take    = in_valid_i && !in_stall_o;

  // ranges beyond the distance width saturate
  assign rng_w   = CMPW'(in_data_i.range_mm);
  assign rng_sat = (rng_w > CMPW'(DIST_MAX)) ? DIST_MAX : rng_w[DB-1:0];

  assign front_gt_clear = CMPW'(fdist_q) > CMPW'(clear_q);
  assign front_lt_slow  = CMPW'(fdist_q) < CMPW'(slow_q);
  assign err_now        = EW'(desired_q) - EW'(rdist_q);
  assign err_sh         = {err_q, 8'h00};
  assign inc            = mac_acc[IW-1:0];
  assign sum            = SW'(integ_q) + SW'(inc);
  assign tot            = mac_acc[AW-1:16];

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rmin_d      = rmin_q;
    fmin_d      = fmin_q;
    rdist_d     = rdist_q;
    fdist_d     = fdist_q;
    init_done_d = init_done_q;
    wait_d      = wait_q;
    integ_d     = integ_q;
    err_d       = err_q;
    out_load    = 1'b0;
    out_d       = out_q;
    mac_ctrl    = '0;
    mac_mcand   = '0;
    mac_mplier  = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          if (in_data_i.action == ACT_SAMPLE) begin
            if (in_data_i.beam_index <= BEAM_RIGHT_LAST) begin
              if (rng_sat < rmin_q) begin
                rmin_d = rng_sat;
              end
            end else if ((in_data_i.beam_index >= BEAM_FRONT_FIRST) &&
                         (in_data_i.beam_index <= BEAM_FRONT_LAST)) begin
              if (rng_sat < fmin_q) begin
                fmin_d = rng_sat;
              end
            end else if (in_data_i.beam_index == BEAM_COMMIT) begin
              rdist_d = rmin_q;
              fdist_d = fmin_q;
              rmin_d  = DIST_MAX;
              fmin_d  = DIST_MAX;
            end
          end else if (!init_done_q) begin
            // standstill count, then drive straight until the front closes in
            out_load           = 1'b1;
            out_d.mode         = MODE_INIT;
            out_d.linear_speed = '0;
            out_d.angular_rate = '0;
            if (wait_q < initt_q) begin
              wait_d = wait_q + 8'd1;
            end else if (front_gt_clear) begin
              out_d.linear_speed = SPD_INIT;
            end else begin
              init_done_d = 1'b1;
            end
          end else if (front_gt_clear) begin
            // follow: increment = err * tick_period
            err_d          = err_now;
            mac_ctrl.load  = 1'b1;
            mac_ctrl.clr   = 1'b1;
            mac_mcand      = AW'(err_now);
            mac_mplier     = GAIN_BITS'(period_q);
            cnt_d          = '0;
            state_d        = ST_INC;
          end else begin
            out_load           = 1'b1;
            out_d.mode         = MODE_AVOID;
            out_d.linear_speed = '0;
            out_d.angular_rate = {1'b0, turn_q};
            integ_d            = '0;
          end
        end
      end
      ST_INC: begin
        mac_ctrl.step = 1'b1;
        cnt_d         = cnt_q + CNTW'(1);
        if (cnt_q == CNTW'(TICK_BITS - 1)) begin
          cnt_d   = '0;
          state_d = ST_SAT;
        end
      end
      ST_SAT: begin
        if (sum > INTEG_MAX_S) begin
          integ_d = INTEG_MAX_S[IB-1:0];
        end else if (sum < INTEG_MIN_S) begin
          integ_d = INTEG_MIN_S[IB-1:0];
        end else begin
          integ_d = sum[IB-1:0];
        end
        // integral term: integrator * integ_gain
        mac_ctrl.load = 1'b1;
        mac_ctrl.clr  = 1'b1;
        mac_mcand     = AW'(integ_d);
        mac_mplier    = igain_q;
        state_d       = ST_MUL_I;
      end
      ST_MUL_I: begin
        mac_ctrl.step = 1'b1;
        cnt_d         = cnt_q + CNTW'(1);
        if (cnt_q == CNTW'(GAIN_BITS - 1)) begin
          cnt_d   = '0;
          state_d = ST_LDP;
        end
      end
      ST_LDP: begin
        // proportional term err * prop_gain * 256 adds onto the integral term
        mac_ctrl.load = 1'b1;
        mac_mcand     = AW'(err_sh);
        mac_mplier    = pgain_q;
        state_d       = ST_MUL_P;
      end
      ST_MUL_P: begin
        mac_ctrl.step = 1'b1;
        cnt_d         = cnt_q + CNTW'(1);
        if (cnt_q == CNTW'(GAIN_BITS - 1)) begin
          cnt_d   = '0;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (slot_free) begin
          out_load           = 1'b1;
          out_d.mode         = MODE_FOLLOW;
          out_d.linear_speed = front_lt_slow ? SPD_SLOW : SPD_FAST;
          if (tot > ANG_MAX) begin
            out_d.angular_rate = ANG_MAX[15:0];
          end else if (tot < ANG_MIN) begin
            out_d.angular_rate = ANG_MIN[15:0];
          end else begin
            out_d.angular_rate = tot[15:0];
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rmin_q      <= DIST_MAX;
      fmin_q      <= DIST_MAX;
      rdist_q     <= DIST_MAX;
      fdist_q     <= DIST_MAX;
      init_done_q <= 1'b0;
      wait_q      <= '0;
      integ_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rmin_q      <= rmin_d;
      fmin_q      <= fmin_d;
      rdist_q     <= rdist_d;
      fdist_q     <= fdist_d;
      init_done_q <= init_done_d;
      wait_q      <= wait_d;
      integ_q     <= integ_d;
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    err_q <= err_d;
    out_q <= out_d;
  end

  // configuration registers, masked to their widths
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desired_q <= RST_DESIRED;
      clear_q   <= RST_CLEAR;
      slow_q    <= RST_SLOW;
      pgain_q   <= RST_PGAIN;
      igain_q   <= RST_IGAIN;
      period_q  <= RST_PERIOD;
      initt_q   <= RST_INITT;
      turn_q    <= RST_TURN;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DESIRED: desired_q <= cfg_data_i;
        REG_CLEAR:   clear_q   <= cfg_data_i;
        REG_SLOW:    slow_q    <= cfg_data_i;
        REG_PGAIN:   pgain_q   <= cfg_data_i;
        REG_IGAIN:   igain_q   <= cfg_data_i;
        REG_PERIOD:  period_q  <= cfg_data_i[7:0];
        REG_INITT:   initt_q   <= cfg_data_i[7:0];
        REG_TURN:    turn_q    <= cfg_data_i[14:0];
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a finished follow computation always lands in the output register
  a_out_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && state_d == ST_IDLE) |=> out_valid_q)
    else $error("follow result not registered");

  // avoidance clears the integrator
  a_avoid_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_d.mode == MODE_AVOID) |=> (integ_q == '0))
    else $error("integrator not cleared on avoid");

  // once armed, the block stays armed
  a_armed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(init_done_q))
    else $error("init_done dropped");

  // the PI loop only starts after arming
  a_follow_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && state_d == ST_INC) |-> init_done_q)
    else $error("follow started before arming");

endmodule

`default_nettype wire

/* test/nav_command_checker.sv */
// Checker: tracks config writes and input transfers, predicts commands and compares them.
module nav_command_checker
  import wfpn_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  nav_in_t     in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  nav_out_t    out_data_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output int          pending_o,
  output int          mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint INTEG_HI = (longint'(1) <<< (DEF_INTEG_BITS - 1)) - 1;
  localparam longint INTEG_LO = -INTEG_HI - 1;

  // register copies
  logic [15:0] set_point, clear_mm, slow_mm, kp, ki;
  logic [7:0]  dt, hold_ticks;
  logic [14:0] spin_rate;

  // scan and control state
  logic [15:0] right_acc, front_acc, right_dist, front_dist;
  logic        armed;
  logic [7:0]  hold_count;
  longint      integ;

  nav_out_t    expected_cmds[$];
  int          mismatch_count;

  // Returns 1 with the command a tick produces; samples only update the scan.
  function automatic bit predict_transfer(input nav_in_t it, output nav_out_t cmd);
    longint err, acc, total;
    cmd = '0;
    if (it.action == ACT_SAMPLE) begin
      if (it.beam_index <= BEAM_RIGHT_LAST) begin
        if (it.range_mm < right_acc) right_acc = it.range_mm;
      end else if (it.beam_index >= BEAM_FRONT_FIRST && it.beam_index <= BEAM_FRONT_LAST) begin
        if (it.range_mm < front_acc) front_acc = it.range_mm;
      end else if (it.beam_index == BEAM_COMMIT) begin
        right_dist = right_acc;
        front_dist = front_acc;
        right_acc  = '1;
        front_acc  = '1;
      end
      return 1'b0;
    end
    cmd.mode = MODE_INIT;
    if (!armed) begin
      if (hold_count < hold_ticks) begin
        hold_count = hold_count + 8'd1;
      end else if (front_dist > clear_mm) begin
        cmd.linear_speed = SPD_INIT;
      end else begin
        armed = 1'b1;
      end
    end else if (front_dist > clear_mm) begin
      err = longint'(set_point) - longint'(right_dist);
      acc = integ + err * longint'(dt);
      if (acc > INTEG_HI) acc = INTEG_HI;
      else if (acc < INTEG_LO) acc = INTEG_LO;
      integ = acc;
      // floor of (P term in Q16 + I term in Q16) / 2^16
      total = (err * longint'(kp) * 256 + integ * longint'(ki)) >>> 16;
      if (total > 32767) total = 32767;
      else if (total < -32768) total = -32768;
      cmd.angular_rate = total[15:0];
      cmd.linear_speed = (front_dist < slow_mm) ? SPD_SLOW : SPD_FAST;
      cmd.mode = MODE_FOLLOW;
    end else begin
      cmd.angular_rate = {1'b0, spin_rate};
      cmd.mode = MODE_AVOID;
      integ = 0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    nav_out_t cmd;
    nav_out_t want;
    if (!rst_ni) begin
      set_point  = RST_DESIRED;
      clear_mm   = RST_CLEAR;
      slow_mm    = RST_SLOW;
      kp         = RST_PGAIN;
      ki         = RST_IGAIN;
      dt         = RST_PERIOD;
      hold_ticks = RST_INITT;
      spin_rate  = RST_TURN;
      right_acc  = '1;
      front_acc  = '1;
      right_dist = '1;
      front_dist = '1;
      armed      = 1'b0;
      hold_count = '0;
      integ      = 0;
      expected_cmds.delete();
      mismatch_count = 0;
      pending_o    <= 0;
      mismatches_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_DESIRED: set_point  = cfg_data_i;
          REG_CLEAR:   clear_mm   = cfg_data_i;
          REG_SLOW:    slow_mm    = cfg_data_i;
          REG_PGAIN:   kp         = cfg_data_i;
          REG_IGAIN:   ki         = cfg_data_i;
          REG_PERIOD:  dt         = cfg_data_i[7:0];
          REG_INITT:   hold_ticks = cfg_data_i[7:0];
          REG_TURN:    spin_rate  = cfg_data_i[14:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i && predict_transfer(in_data_i, cmd))
        expected_cmds.push_back(cmd);
      if (out_valid_i && !out_stall_i) begin
        if (expected_cmds.size() == 0) begin
          mismatch_count++;
          $display("%0t: command with none expected: expected nothing, actual %0d/%0d/%0d",
                   $time, out_data_i.linear_speed, out_data_i.angular_rate, out_data_i.mode);
        end else begin
          want = expected_cmds.pop_front();
          if (out_data_i.linear_speed !== want.linear_speed) begin
            mismatch_count++;
            $display("%0t: linear_speed expected %0d actual %0d",
                     $time, want.linear_speed, out_data_i.linear_speed);
          end
          if (out_data_i.angular_rate !== want.angular_rate) begin
            mismatch_count++;
            $display("%0t: angular_rate expected %0d actual %0d",
                     $time, want.angular_rate, out_data_i.angular_rate);
          end
          if (out_data_i.mode !== want.mode) begin
            mismatch_count++;
            $display("%0t: mode expected %0d actual %0d", $time, want.mode, out_data_i.mode);
          end
        end
      end
      pending_o    <= expected_cmds.size();
      mismatches_o <= mismatch_count;
    end
  end

endmodule

/* test/tb_wall_follow_pi_navigator.sv */
// Testbench top: clock, reset, scan and tick stimulus, config phases and verdict.
module tb_wall_follow_pi_navigator
  import wfpn_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET  = 1950;  // input transfers over the whole run
  localparam int PHASES       = 10;    // config settings visited by the random part
  localparam int DRAIN_CYCLES = 64;    // margin for a follow tick to finish

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  nav_in_t     in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  nav_out_t    out_data;
  logic        cfg_we    = 1'b0;
  cfg_reg_e    cfg_idx   = REG_DESIRED;
  logic [15:0] cfg_data  = '0;

  int          pending_count;
  int          mismatch_total;

  // Last written register values, only to aim ranges near the thresholds.
  logic [15:0] cfg_shadow [8];
  int          burst_left = 0;
  int          sent_items = 0;

  // Receiver stall pattern state
  int          stall_run   = 0;
  int          stall_style = 0;
  int          style_left  = 0;

  wall_follow_pi_navigator i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  nav_command_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending_count),
    .mismatches_o (mismatch_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: switch at random between no stalls, short random stalls and long
  // stall runs, so gaps land on every phase of a command.
  always @(posedge clk) begin
    if (style_left == 0) begin
      stall_style <= $urandom_range(0, 2);
      style_left  <= $urandom_range(50, 400);
    end else begin
      style_left <= style_left - 1;
    end
    if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else begin
      stall_run <= $urandom_range(0, (stall_style == 2) ? 12 : 3);
      case (stall_style)
        0: out_stall <= 1'b0;
        1: out_stall <= 1'($urandom_range(0, 1));
        default: out_stall <= ($urandom_range(0, 2) != 0);
      endcase
    end
  end

  // One input transfer. The sender runs in bursts; between bursts valid may drop
  // for a random gap. Payload holds while stalled.
  task automatic send_transfer(input logic act, input logic [9:0] beam,
                               input logic [15:0] range);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= '{action: act, beam_index: beam, range_mm: range};
    do @(posedge clk); while (in_stall);
    sent_items++;
  endtask

  // Drop valid, wait for the last command, then let a follow tick finish.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Back-to-back writes of all eight registers; enable drops once at the end.
  task automatic write_config(input logic [15:0] vals [8]);
    for (int r = 0; r < 8; r++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= cfg_reg_e'(r);
      cfg_data <= vals[r];
      @(posedge clk);
      cfg_shadow[r] = vals[r];
    end
    cfg_we <= 1'b0;
  endtask

  // Ranges cluster around the current thresholds so mode changes happen often.
  function automatic logic [15:0] pick_range();
    int base;
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom);
      4, 5: base = cfg_shadow[REG_DESIRED];
      6, 7: base = cfg_shadow[REG_CLEAR];
      default: base = cfg_shadow[REG_SLOW];
    endcase
    base += int'($urandom_range(0, 600)) - 300;
    if (base < 0) base = 0;
    if (base > 65535) base = 65535;
    return base[15:0];
  endfunction

  function automatic logic [15:0] typical_setting(input cfg_reg_e r);
    case (r)
      REG_DESIRED: return 16'($urandom_range(200, 1500));
      REG_CLEAR:   return 16'($urandom_range(300, 1200));
      REG_SLOW:    return 16'($urandom_range(500, 2000));
      REG_PGAIN:   return 16'($urandom_range(0, 1024));
      REG_IGAIN:   return 16'($urandom_range(0, 512));
      default:     return 16'($urandom);  // narrow registers: upper bits get masked
    endcase
  endfunction

  // A scan: samples over the sectors (front sometimes left empty), and
  // optionally a commit followed by a few ticks whose unused fields are random.
  task automatic send_scan(input bit closed);
    int          n;
    bit          front_on;
    logic [9:0]  beam;
    n        = $urandom_range(1, 10);
    front_on = ($urandom_range(0, 2) != 0);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: beam = 10'($urandom_range(0, 49));
        4, 5, 6, 7: beam = front_on ? 10'($urandom_range(51, 69)) : 10'($urandom_range(0, 49));
        8: beam = BEAM_RIGHT_LAST + 10'd1;
        default: beam = 10'($urandom_range(70, 1023));
      endcase
      send_transfer(ACT_SAMPLE, beam, pick_range());
    end
    if (closed) begin
      send_transfer(ACT_SAMPLE, BEAM_COMMIT, 16'($urandom));
      repeat ($urandom_range(1, 3)) send_transfer(ACT_TICK, 10'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    logic [15:0] vals [8];
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Defaults, but a short standstill so the init drive phase shows up early.
    vals = '{RST_DESIRED, RST_CLEAR, RST_SLOW, RST_PGAIN, RST_IGAIN,
             16'(RST_PERIOD), 16'd2, 16'(RST_TURN)};
    write_config(vals);

    // Directed: standstill, init drive, sector edges, unused beams, arming,
    // avoid, slow and fast follow, ignored tick fields, empty scan.
    send_transfer(ACT_TICK,   10'd0,       16'h0000);  // standstill
    send_transfer(ACT_TICK,   10'd1023,    16'hFFFF);  // standstill
    send_transfer(ACT_TICK,   10'h2AA,     16'h5555);  // init drive, front at max
    send_transfer(ACT_SAMPLE, 10'd0,       16'h0000);
    send_transfer(ACT_SAMPLE, BEAM_RIGHT_LAST,  16'hFFFF);
    send_transfer(ACT_SAMPLE, 10'd50,      16'h0000);  // gap beam between sectors
    send_transfer(ACT_SAMPLE, BEAM_FRONT_FIRST, 16'd500);
    send_transfer(ACT_SAMPLE, BEAM_FRONT_LAST,  16'hFFFF);
    send_transfer(ACT_SAMPLE, 10'd70,      16'h0000);
    send_transfer(ACT_SAMPLE, 10'd118,     16'h0000);
    send_transfer(ACT_SAMPLE, 10'd120,     16'h0000);
    send_transfer(ACT_SAMPLE, 10'd1023,    16'h0000);
    send_transfer(ACT_SAMPLE, BEAM_COMMIT, 16'h5A5A);  // right 0, front 500
    send_transfer(ACT_TICK,   10'd0,       16'h0000);  // arms
    send_transfer(ACT_TICK,   10'd0,       16'h0000);  // avoid
    send_transfer(ACT_SAMPLE, 10'd60,      16'd900);
    send_transfer(ACT_SAMPLE, 10'd10,      16'd650);
    send_transfer(ACT_SAMPLE, BEAM_COMMIT, 16'h0000);
    send_transfer(ACT_TICK,   10'd0,       16'h0000);  // follow, slow
    send_transfer(ACT_TICK,   BEAM_COMMIT, 16'h0000);  // tick ignores the commit beam
    send_transfer(ACT_SAMPLE, 10'd30,      16'h0000);
    send_transfer(ACT_SAMPLE, BEAM_COMMIT, 16'hA5A5);  // right 0, front at max
    send_transfer(ACT_TICK,   10'd0,       16'h0000);  // follow, fast
    send_transfer(ACT_SAMPLE, BEAM_COMMIT, 16'h0000);  // empty scan: both at max
    send_transfer(ACT_TICK,   10'd0,       16'h0000);  // large negative error

    // Random phases: defaults, all zero, all ones but a usable clear
    // distance, permanent avoid, then mixed settings.
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        wait_idle();
        for (int r = 0; r < 8; r++) begin
          case (p)
            1: vals[r] = '0;
            2: vals[r] = (r == REG_CLEAR) ? typical_setting(cfg_reg_e'(r)) : 16'hFFFF;
            3: vals[r] = (r == REG_CLEAR) ? 16'hFFFF : typical_setting(cfg_reg_e'(r));
            default:
              case ($urandom_range(0, 5))
                0: vals[r] = '0;
                1: vals[r] = 16'hFFFF;
                default: vals[r] = typical_setting(cfg_reg_e'(r));
              endcase
          endcase
        end
        write_config(vals);
      end
      while (sent_items < (p + 1) * ITEM_TARGET / PHASES) begin
        case ($urandom_range(0, 9))
          0: send_transfer(ACT_SAMPLE, 10'($urandom), 16'($urandom));
          1: send_transfer(ACT_TICK, 10'($urandom), 16'($urandom));
          2: send_scan(1'b0);  // scan cut short, no commit
          default: send_scan(1'b1);
        endcase
      end
    end

    wait_idle();
    if (mismatch_total == 0 && pending_count == 0) begin
      $display("PASS wall_follow_pi_navigator");
    end else begin
      $display("FAIL wall_follow_pi_navigator");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("FAIL wall_follow_pi_navigator");
    $finish;
  end

endmodule
